// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the projection pipeline checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Clocked implication that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/pry_pkg.sv =====
// ----------------------------------------------------------------------------
// pry_pkg
// Types, constants and the quarter-wave sine table for the projection pipe.
// ----------------------------------------------------------------------------
package pry_pkg;

    localparam int unsigned NUM_DIV_CELLS = 7;

    // Configuration register indexes
    localparam logic [1:0] REG_Y_ANGLE      = 2'd0;
    localparam logic [1:0] REG_DEPTH_OFFSET = 2'd1;
    localparam logic [1:0] REG_CENTER_X     = 2'd2;
    localparam logic [1:0] REG_CENTER_Y     = 2'd3;

    localparam logic [9:0] DEPTH_OFFSET_RST = 10'd440;
    localparam logic [9:0] CENTER_X_RST     = 10'd160;
    localparam logic [8:0] CENTER_Y_RST     = 9'd128;

    localparam logic signed [11:0] DEPTH_MIN = 12'sd316;
    localparam logic signed [11:0] DEPTH_MAX = 12'sd562;
    localparam logic signed [9:0]  XR_MAX    = 10'sd140;
    localparam logic signed [9:0]  XR_MIN    = -10'sd140;

    // Sine, first quadrant, unsigned 1.8 fixed point
    localparam logic [8:0] SINE_QUARTER [0:64] = '{
        9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,  9'd50,
        9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,  9'd98,  9'd104,
        9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137, 9'd142, 9'd147, 9'd152,
        9'd157, 9'd162, 9'd167, 9'd172, 9'd177, 9'd181, 9'd185, 9'd190, 9'd194,
        9'd198, 9'd202, 9'd206, 9'd209, 9'd213, 9'd216, 9'd220, 9'd223, 9'd226,
        9'd229, 9'd231, 9'd234, 9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247,
        9'd248, 9'd250, 9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256,
        9'd256, 9'd256
    };

    // One divider lane: partial remainder, numerator bits still to shift in,
    // quotient bits so far, and the flags that decide saturation.
    typedef struct packed {
        logic [10:0] rem;
        logic [6:0]  bits;
        logic [6:0]  quo;
        logic        ovf;
        logic        zero;
        logic        neg;
    } lane_t;

    typedef struct packed {
        lane_t       lx;
        lane_t       ly;
        logic [10:0] den;
        logic        in_range;
    } div_data_t;

    function automatic logic signed [9:0] sine8(input logic [7:0] angle);
        logic [5:0] step;
        logic [6:0] idx;
        logic [8:0] mag;
        step = angle[5:0];
        idx  = angle[6] ? 7'(7'd64 - {1'b0, step}) : {1'b0, step};
        mag  = SINE_QUARTER[idx];
        return angle[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ===== hw/rtl/point_rotate_y_project.sv =====
// ----------------------------------------------------------------------------
// point_rotate_y_project
// Rotates a signed 8-bit point about Y and projects it to screen coordinates.
// ----------------------------------------------------------------------------
//  channel   dir  ports                       contents
//  s_axis    in   s_tvalid/s_tready/s_tdata   point_x, point_y, point_z
//  m_axis    out  m_tvalid/m_tready/m_tdata   screen_x, screen_y
//                 m_tuser                     in_range
//  cfg       in   cfg_wr_en/cfg_addr/cfg_wdata register writes
//
//  One point per cycle sustained while m_tready is high. Stages: three front
//  stages (products, depth and numerators, divider setup), seven division
//  cells resolving one quotient bit each, and the output register.
//  Reset (aresetn low, synchronous) empties the pipe and loads register
//  defaults. A stall on m_tready fills empty stages first and reaches
//  s_tready only once every stage holds a point.
// ----------------------------------------------------------------------------
module point_rotate_y_project import pry_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // point_x[7:0], point_y[15:8], point_z[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // screen_x[11:0], screen_y[22:12], zero[23]
    output logic [0:0]  m_tuser,   // in_range[0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);

    logic [7:0] y_angle_reg;
    logic [9:0] depth_offset_reg;
    logic [9:0] center_x_reg;
    logic [8:0] center_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_angle_reg      <= '0;
            depth_offset_reg <= DEPTH_OFFSET_RST;
            center_x_reg     <= CENTER_X_RST;
            center_y_reg     <= CENTER_Y_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_Y_ANGLE:      y_angle_reg      <= cfg_wdata[7:0];
                REG_DEPTH_OFFSET: depth_offset_reg <= cfg_wdata;
                REG_CENTER_X:     center_x_reg     <= cfg_wdata;
                REG_CENTER_Y:     center_y_reg     <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic      chain_valid [NUM_DIV_CELLS+1];
    logic      chain_ready [NUM_DIV_CELLS+1];
    div_data_t chain_data  [NUM_DIV_CELLS+1];

    pry_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .y_angle      (y_angle_reg),
        .depth_offset (depth_offset_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_x         ($signed(s_tdata[7:0])),
        .in_y         ($signed(s_tdata[15:8])),
        .in_z         ($signed(s_tdata[23:16])),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_cell
        pry_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Output stage: saturate, apply sign, add screen centre
    logic        m_valid_reg;
    logic [11:0] screen_x_reg, screen_x_next;
    logic [10:0] screen_y_reg, screen_y_next;
    logic        in_range_reg;
    logic        out_adv;
    logic [7:0]  qx, qy;
    div_data_t   fin;

    function automatic logic [7:0] finish_quo(input lane_t ln);
        logic [7:0] q;
        if (ln.zero) begin
            q = 8'h00;
        end else if (ln.ovf) begin
            q = ln.neg ? 8'h80 : 8'h7F;
        end else begin
            q = ln.neg ? 8'(-{1'b0, ln.quo}) : {1'b0, ln.quo};
        end
        return q;
    endfunction

    assign fin     = chain_data[NUM_DIV_CELLS];
    assign out_adv = !m_valid_reg || m_tready;
    assign chain_ready[NUM_DIV_CELLS] = out_adv;

    always_comb begin
        qx            = finish_quo(fin.lx);
        qy            = finish_quo(fin.ly);
        screen_x_next = {2'b00, center_x_reg} + {{4{qx[7]}}, qx};
        screen_y_next = {2'b00, center_y_reg} + {{3{qy[7]}}, qy};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg  <= chain_valid[NUM_DIV_CELLS];
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
            in_range_reg <= fin.in_range;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {1'b0, screen_y_reg, screen_x_reg};
    assign m_tuser[0] = in_range_reg;

endmodule

// ===== hw/rtl/pry_front.sv =====
// ----------------------------------------------------------------------------
// pry_front
// Rotation about Y, depth offset, numerator scaling and divider setup.
// ----------------------------------------------------------------------------
module pry_front import pry_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       y_angle,
    input  logic [9:0]       depth_offset,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic signed [7:0] in_x,
    input  logic signed [7:0] in_y,
    input  logic signed [7:0] in_z,
    output logic             out_valid,
    input  logic             out_ready,
    output div_data_t        out_data
);

    // Stage A: rotated product terms
    logic                a_valid_reg;
    logic signed [8:0]   xc_reg, zs_reg, zc_reg, xs_reg;
    logic signed [7:0]   a_y_reg;
    // Stage B: numerators and depth
    logic                b_valid_reg;
    logic signed [17:0]  numx_reg, numy_reg;
    logic signed [11:0]  d_reg;
    logic                b_range_reg;
    // Stage C: divider setup
    logic                c_valid_reg;
    div_data_t           c_data_reg;

    logic a_adv, b_adv, c_adv;

    logic signed [9:0]  sin_v, cos_v;
    logic signed [17:0] p_xc, p_zs, p_zc, p_xs;
    logic signed [9:0]  xr, zr;
    logic signed [11:0] d_next;
    logic signed [17:0] xe, ye, numx_next, numy_next;
    logic               range_next;
    logic [16:0]        nx_mag, ny_mag;
    logic [10:0]        d_mag;
    div_data_t          c_data_next;

    assign c_adv    = !c_valid_reg || out_ready;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    always_comb begin
        sin_v = sine8(y_angle);
        cos_v = sine8(8'(y_angle + 8'd64));
        p_xc  = in_x * cos_v;
        p_zs  = in_z * sin_v;
        p_zc  = in_z * cos_v;
        p_xs  = in_x * sin_v;
    end

    always_comb begin
        xr     = {xc_reg[8], xc_reg} + {zs_reg[8], zs_reg};
        zr     = {zc_reg[8], zc_reg} - {xs_reg[8], xs_reg};
        d_next = $signed({2'b00, depth_offset}) + {{2{zr[9]}}, zr};
        xe     = {{8{xr[9]}}, xr};
        ye     = {{10{a_y_reg[7]}}, a_y_reg};
        // times 400 = 256 + 128 + 16
        numx_next = (xe <<< 8) + (xe <<< 7) + (xe <<< 4);
        numy_next = (ye <<< 8) + (ye <<< 7) + (ye <<< 4);
        range_next = (d_next >= DEPTH_MIN) && (d_next <= DEPTH_MAX) &&
                     (xr >= XR_MIN) && (xr <= XR_MAX);
    end

    always_comb begin
        nx_mag = numx_reg[17] ? 17'(-numx_reg) : numx_reg[16:0];
        ny_mag = numy_reg[17] ? 17'(-numy_reg) : numy_reg[16:0];
        d_mag  = d_reg[11] ? 11'(-d_reg) : d_reg[10:0];

        // Quotient of 128 or more saturates; the cells resolve the low 7 bits.
        c_data_next.lx.rem  = {1'b0, nx_mag[16:7]};
        c_data_next.lx.bits = nx_mag[6:0];
        c_data_next.lx.quo  = '0;
        c_data_next.lx.ovf  = {1'b0, nx_mag[16:7]} >= d_mag;
        c_data_next.lx.zero = (nx_mag == '0);
        c_data_next.lx.neg  = numx_reg[17] ^ d_reg[11];

        c_data_next.ly.rem  = {1'b0, ny_mag[16:7]};
        c_data_next.ly.bits = ny_mag[6:0];
        c_data_next.ly.quo  = '0;
        c_data_next.ly.ovf  = {1'b0, ny_mag[16:7]} >= d_mag;
        c_data_next.ly.zero = (ny_mag == '0);
        c_data_next.ly.neg  = numy_reg[17] ^ d_reg[11];

        c_data_next.den      = d_mag;
        c_data_next.in_range = b_range_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= in_valid;
                xc_reg      <= p_xc[16:8];
                zs_reg      <= p_zs[16:8];
                zc_reg      <= p_zc[16:8];
                xs_reg      <= p_xs[16:8];
                a_y_reg     <= in_y;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
                numx_reg    <= numx_next;
                numy_reg    <= numy_next;
                d_reg       <= d_next;
                b_range_reg <= range_next;
            end
            if (c_adv) begin
                c_valid_reg <= b_valid_reg;
                c_data_reg  <= c_data_next;
            end
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// ===== hw/rtl/pry_div_cell.sv =====
// ----------------------------------------------------------------------------
// pry_div_cell
// One restoring-division step for both projection lanes, registered.
// ----------------------------------------------------------------------------
module pry_div_cell import pry_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_data_t out_data
);

    logic      valid_reg;
    div_data_t data_reg;
    div_data_t data_next;
    logic      adv;

    function automatic lane_t div_step(input lane_t ln, input logic [10:0] den);
        logic [11:0] sh;
        logic        ge;
        lane_t       res;
        sh  = {ln.rem, ln.bits[6]};
        ge  = sh >= {1'b0, den};
        res = ln;
        res.rem  = ge ? 11'(sh - {1'b0, den}) : sh[10:0];
        res.bits = {ln.bits[5:0], 1'b0};
        res.quo  = {ln.quo[5:0], ge};
        return res;
    endfunction

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        data_next    = in_data;
        data_next.lx = div_step(in_data.lx, in_data.den);
        data_next.ly = div_step(in_data.ly, in_data.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
            data_reg  <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/pry_checker.sv =====
// ----------------------------------------------------------------------------
// pry_checker
// Port-level checks on the projection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pry_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result holds until transferred
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the pipe
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // With no result pending, every stage can advance, so input is open
    `ASSERT_CLK(a_ready_when_drained, aclk, aresetn, !m_tvalid |-> s_tready)

    // Padding bit above screen_y stays clear
    `ASSERT_CLK(a_pad_zero, aclk, aresetn, m_tvalid |-> !m_tdata[23])

endmodule

bind point_rotate_y_project pry_checker u_pry_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/point_rotate_y_project_tb.sv =====
// ----------------------------------------------------------------------------
// point_rotate_y_project_tb
// Self-checking bench for the Y-rotation and perspective projection pipe.
// Points go in on the s_ stream and screen positions come back on the m_
// stream. Each accepted point is projected by a local fixed-point model and
// queued. Each result transfer is compared against the head of that queue.
// Directed points cover full-scale products, the range flag bounds, and zero
// and negative depths. Random phases follow with fresh register settings.
// ----------------------------------------------------------------------------
module point_rotate_y_project_tb import pry_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [11:0] sx;
        logic [10:0] sy;
        logic        ok;
    } screen_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // point_x[7:0], point_y[15:8], point_z[23:16]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // screen_x[11:0], screen_y[22:12], zero[23]
    logic [0:0]  m_tuser;          // in_range[0]
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = REG_Y_ANGLE;
    logic [9:0]  cfg_wdata = '0;

    // register copies used for projection
    int angle_reg = 0;
    int depth_reg = int'(DEPTH_OFFSET_RST);
    int cx_reg    = int'(CENTER_X_RST);
    int cy_reg    = int'(CENTER_Y_RST);

    screen_t pending_q[$];
    bit      steady      = 1'b0;
    int      mismatches  = 0;
    int      points_sent = 0;
    int      settings    = 0;
    int      in_range_n  = 0;

    point_rotate_y_project i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int trig_lookup(input logic [7:0] ang);
        int mag;
        mag = ang[6] ? int'(SINE_QUARTER[64 - ang[5:0]]) : int'(SINE_QUARTER[ang[5:0]]);
        return ang[7] ? -mag : mag;
    endfunction

    // Truncating divide, clamped to signed 8 bits; zero depth saturates by sign.
    function automatic int clamp_quotient(input int num, input int den);
        int q;
        if (den == 0) begin
            q = (num > 0) ? 127 : ((num < 0) ? -128 : 0);
        end else begin
            q = num / den;
        end
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        return q;
    endfunction

    function automatic screen_t project_point(input logic signed [7:0] x8,
                                              input logic signed [7:0] y8,
                                              input logic signed [7:0] z8);
        int x, y, z, s, c, xr, zr, d;
        screen_t r;
        x = x8;
        y = y8;
        z = z8;
        s = trig_lookup(8'(angle_reg));
        c = trig_lookup(8'(angle_reg + 64));
        // keep each term at full width so that +128 survives
        xr = ((x * c) >>> 8) + ((z * s) >>> 8);
        zr = ((z * c) >>> 8) - ((x * s) >>> 8);
        d  = depth_reg + zr;
        r.sx = 12'(cx_reg + clamp_quotient(xr * 400, d));
        r.sy = 11'(cy_reg + clamp_quotient(y * 400, d));
        r.ok = (d >= 316) && (d <= 562) && (xr >= -140) && (xr <= 140);
        return r;
    endfunction

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge aclk) begin
        screen_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with no point outstanding: tdata %h", m_tdata);
                mismatches++;
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[11:0] !== e.sx) begin
                    $error("screen_x expected %0d got %0d",
                           $signed(e.sx), $signed(m_tdata[11:0]));
                    mismatches++;
                end
                if (m_tdata[22:12] !== e.sy) begin
                    $error("screen_y expected %0d got %0d",
                           $signed(e.sy), $signed(m_tdata[22:12]));
                    mismatches++;
                end
                if (m_tuser[0] !== e.ok) begin
                    $error("in_range expected %0d got %0d", e.ok, m_tuser[0]);
                    mismatches++;
                end
                if (e.ok) in_range_n++;
            end
        end
    end

    task automatic send_point(input logic [7:0] px, input logic [7:0] py,
                              input logic [7:0] pz);
        if (!steady) begin
            while ($urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(project_point(px, py, pz));
        points_sent++;
    endtask

    // Drop valid, let every result drain, then allow the pipe to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic load_settings(input int ang, input int dep, input int cx, input int cy);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_Y_ANGLE;
        cfg_wdata <= 10'(ang);
        @(posedge aclk);
        cfg_addr  <= REG_DEPTH_OFFSET;
        cfg_wdata <= 10'(dep);
        @(posedge aclk);
        cfg_addr  <= REG_CENTER_X;
        cfg_wdata <= 10'(cx);
        @(posedge aclk);
        cfg_addr  <= REG_CENTER_Y;
        cfg_wdata <= 10'(cy);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        angle_reg = ang & 255;
        depth_reg = dep & 1023;
        cx_reg    = cx & 1023;
        cy_reg    = cy & 511;
        settings++;
    endtask

    function automatic logic [7:0] rand_coord();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'h80;
                1: return 8'h7f;
                2: return 8'h00;
                default: return 8'hff;
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic int pick_reg(input int hi);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic test_reset_defaults();
        settings++;
        send_point(8'sd0, 8'sd0, 8'sd0);
        send_point(8'sd127, -8'sd128, 8'sd127);
        send_point(-8'sd128, 8'sd127, -8'sd128);
    endtask

    // Angles 128 and 192 put -1.0 in the table, so -128 terms become +128.
    task automatic test_full_scale_terms();
        load_settings(128, 440, 160, 128);
        send_point(-8'sd128, -8'sd128, -8'sd128);
        send_point(-8'sd128, 8'sd127, 8'sd127);
        load_settings(192, 1023, 1023, 511);
        send_point(-8'sd128, 8'sd0, -8'sd128);
        send_point(8'sd127, 8'sd127, -8'sd128);
    endtask

    task automatic test_in_range_bounds();
        // rotated X at +-140 and just past it, depth at or next to the offset
        load_settings(32, 440, 0, 0);
        send_point(8'sd100, 8'sd0, 8'sd100);
        send_point(8'sd101, -8'sd128, 8'sd100);
        send_point(-8'sd99, 8'sd127, -8'sd99);
        send_point(-8'sd100, 8'sd1, -8'sd99);
        // depth at 316, 315, 562, 563
        load_settings(0, 440, 160, 128);
        send_point(8'sd0, 8'sd0, -8'sd124);
        send_point(8'sd0, 8'sd0, -8'sd125);
        send_point(8'sd0, 8'sd0, 8'sd122);
        send_point(8'sd0, 8'sd0, 8'sd123);
    endtask

    task automatic test_zero_and_negative_depth();
        load_settings(0, 100, 512, 256);
        send_point(8'sd5, -8'sd7, -8'sd100);
        send_point(-8'sd3, 8'sd9, -8'sd100);
        send_point(8'sd0, 8'sd0, -8'sd100);
        load_settings(255, 0, 160, 128);
        send_point(8'sd50, -8'sd60, -8'sd50);
        send_point(-8'sd128, 8'sd127, -8'sd128);
    endtask

    task automatic test_random_points();
        int dep;
        for (int ph = 0; ph < 6; ph++) begin
            dep = ($urandom_range(0, 1) == 0) ? $urandom_range(300, 600) : pick_reg(1023);
            load_settings(pick_reg(255), dep, pick_reg(1023), pick_reg(511));
            // first phase runs both sides without gaps
            steady = (ph == 0);
            for (int i = 0; i < 100; i++) begin
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_full_scale_terms();
        test_in_range_bounds();
        test_zero_and_negative_depth();
        test_random_points();
        wait_idle();
        $display("sent %0d points under %0d register settings", points_sent, settings);
        $display("%0d results flagged in range", in_range_n);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
